// ----- rtl/nea_pkg.sv -----
// ----------------------------------------------------------------------------
// nea_pkg
// Shared types and constants of the normal equations accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package nea_pkg;

  localparam int unsigned NeaMaxColumns = 8;
  localparam int unsigned ElemW         = 24;
  localparam int unsigned SumW          = 64;
  localparam int unsigned ProdW         = 2 * ElemW;
  localparam int unsigned ColsW         = 4;
  localparam int unsigned IdxW          = 3;

  // One input row: matrix elements, source value and end-of-run mark.
  typedef struct packed {
    logic signed [ElemW-1:0] elem_0;
    logic signed [ElemW-1:0] elem_1;
    logic signed [ElemW-1:0] elem_2;
    logic signed [ElemW-1:0] elem_3;
    logic signed [ElemW-1:0] elem_4;
    logic signed [ElemW-1:0] elem_5;
    logic signed [ElemW-1:0] elem_6;
    logic signed [ElemW-1:0] elem_7;
    logic signed [ElemW-1:0] source_value;
    logic                    last_row;
  } nea_in_t;

  // One emitted accumulator entry.
  typedef struct packed {
    logic [IdxW-1:0]        row_index;
    logic [IdxW-1:0]        col_index;
    logic                   is_rhs;
    logic signed [SumW-1:0] sum_value;
    logic                   final_entry;
  } nea_out_t;

  // Walker position.
  typedef struct packed {
    logic [IdxW-1:0] row;
    logic [IdxW-1:0] col;
    logic            is_rhs;
    logic            last;
  } nea_pos_t;

  // Walker control.
  typedef struct packed {
    logic start;
    logic advance;
  } nea_walk_ctrl_t;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_ACC     = 5'b00010,
    ST_DRAIN   = 5'b00100,
    ST_EMIT_RD = 5'b01000,
    ST_EMIT_WR = 5'b10000
  } nea_state_e;

endpackage

`default_nettype wire

// ----- rtl/nea_ram.sv -----
// ----------------------------------------------------------------------------
// nea_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module nea_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 44,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/nea_walk.sv -----
// ----------------------------------------------------------------------------
// nea_walk
// Steps through the active accumulator entries: upper Gram triangle row by
// row, then the rhs entries. Produces position and memory address.
// ----------------------------------------------------------------------------
`default_nettype none

module nea_walk
  import nea_pkg::*;
#(
  parameter int unsigned MAX_COLUMNS = NeaMaxColumns,
  localparam int unsigned GramDepth = MAX_COLUMNS * (MAX_COLUMNS + 1) / 2,
  localparam int unsigned Depth     = GramDepth + MAX_COLUMNS,
  localparam int unsigned AddrW     = $clog2(Depth)
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire nea_walk_ctrl_t ctrl_i,
  input  wire logic [ColsW-1:0] cols_i,
  output nea_pos_t            pos_o,
  output logic [AddrW-1:0]    addr_o
);

  logic [IdxW-1:0]  row_q, row_d, col_q, col_d;
  logic             rhs_q, rhs_d;
  logic [AddrW-1:0] base_q, base_d;
  logic [ColsW-1:0] row_inc, col_inc;

  always_comb begin
    row_inc = {1'b0, row_q} + ColsW'(1);
    col_inc = {1'b0, col_q} + ColsW'(1);

    pos_o.row    = row_q;
    pos_o.col    = col_q;
    pos_o.is_rhs = rhs_q;
    pos_o.last   = rhs_q && (row_inc == cols_i);

    if (rhs_q) begin
      addr_o = AddrW'(GramDepth) + AddrW'(row_q);
    end else begin
      addr_o = base_q + AddrW'(col_q - row_q);
    end

    row_d  = row_q;
    col_d  = col_q;
    rhs_d  = rhs_q;
    base_d = base_q;
    if (ctrl_i.start) begin
      row_d  = '0;
      col_d  = '0;
      rhs_d  = 1'b0;
      base_d = '0;
    end else if (ctrl_i.advance) begin
      if (rhs_q) begin
        row_d = IdxW'(row_inc);
      end else if (col_inc == cols_i) begin
        if (row_inc == cols_i) begin
          rhs_d = 1'b1;
          row_d = '0;
          col_d = '0;
        end else begin
          // next row starts on its diagonal
          row_d  = IdxW'(row_inc);
          col_d  = IdxW'(row_inc);
          base_d = base_q + AddrW'(MAX_COLUMNS) - AddrW'(row_q);
        end
      end else begin
        col_d = IdxW'(col_inc);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      rhs_q  <= 1'b0;
      base_q <= '0;
    end else begin
      row_q  <= row_d;
      col_q  <= col_d;
      rhs_q  <= rhs_d;
      base_q <= base_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/nea_mac.sv -----
// ----------------------------------------------------------------------------
// nea_mac
// Registered 24x24 signed multiply, then saturating 64-bit accumulate.
// ----------------------------------------------------------------------------
`default_nettype none

module nea_mac
  import nea_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic signed [ElemW-1:0] a_i,
  input  wire logic signed [ElemW-1:0] b_i,
  input  wire logic signed [SumW-1:0]  old_i,
  output logic signed [SumW-1:0]       sum_o
);

  logic signed [ProdW-1:0] prod_q;
  logic signed [SumW:0]    wide;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  always_comb begin
    wide = {old_i[SumW-1], old_i} + (SumW+1)'(prod_q);
    if (wide[SumW] != wide[SumW-1]) begin
      // overflow: clamp toward the sign of the true sum
      sum_o = wide[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
    end else begin
      sum_o = wide[SumW-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/normal_equations_accumulator_core.sv -----
// ----------------------------------------------------------------------------
// normal_equations_accumulator_core
// Accumulates the least-squares normal equations (A^T A and A^T b) in Q32.32.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : one transfer per matrix row (elements, source value, last
//                 mark). Each row is read-modify-written into one accumulator
//                 RAM, one entry per cycle through a single multiplier. A new
//                 row is taken only once the last one is written back.
//   cfg channel : writes active_columns (n); always ready. Write only while
//                 the block is idle. 0 acts as 1, above MAX_COLUMNS as the max.
//   out channel : after a row marked last, the upper Gram triangle, then the
//                 rhs entries, each read from the RAM before it is registered,
//                 final_entry on the last rhs entry. Accumulators are then
//                 cleared all at once by dropping their valid bits.
//   Reset       : all valid bits cleared (every entry reads as zero), n = 8,
//                 no clearing sweep needed.
//   Stalls      : an output register holds each result; while the receiver
//                 stalls, emission waits and no new row is taken. A row can
//                 be accepted while the final result still waits.
// ----------------------------------------------------------------------------
`default_nettype none

module normal_equations_accumulator_core
  import nea_pkg::*;
#(
  parameter int unsigned MAX_COLUMNS = NeaMaxColumns
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [ColsW-1:0] cfg_data_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire nea_in_t          in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output nea_out_t              out_data_o
);

  localparam int unsigned GramDepth = MAX_COLUMNS * (MAX_COLUMNS + 1) / 2;
  localparam int unsigned Depth     = GramDepth + MAX_COLUMNS;
  localparam int unsigned AddrW     = $clog2(Depth);

  nea_state_e state_q, state_d;

  logic [ColsW-1:0] cols_q, cols_d;   // raw register value
  logic [ColsW-1:0] cols_n;           // clamped column count
  nea_in_t          row_q;            // latched input row
  logic signed [ElemW-1:0] x [NeaMaxColumns];

  // walker
  nea_walk_ctrl_t   walk_ctrl;
  nea_pos_t         walk_pos;
  logic [AddrW-1:0] walk_addr;

  // accumulator RAM and write-back stage
  logic             rd_en;
  logic [SumW-1:0]  rd_data;
  logic             wr_pend_q, wr_pend_d;
  logic [AddrW-1:0] wr_addr_q, wr_addr_d;
  logic [Depth-1:0] vld_q, vld_d;
  logic signed [SumW-1:0] mac_a_old, mac_sum;
  logic signed [ElemW-1:0] op_a, op_b;

  // output register
  logic     out_valid_q, out_valid_d;
  nea_out_t out_q, out_d;
  logic     out_free;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    cols_d = cols_q;
    if (cfg_valid_i) begin
      cols_d = cfg_data_i;
    end
    if (cols_q == '0) begin
      cols_n = ColsW'(1);
    end else if (cols_q > ColsW'(MAX_COLUMNS)) begin
      cols_n = ColsW'(MAX_COLUMNS);
    end else begin
      cols_n = cols_q;
    end
  end

  assign x[0] = row_q.elem_0;
  assign x[1] = row_q.elem_1;
  assign x[2] = row_q.elem_2;
  assign x[3] = row_q.elem_3;
  assign x[4] = row_q.elem_4;
  assign x[5] = row_q.elem_5;
  assign x[6] = row_q.elem_6;
  assign x[7] = row_q.elem_7;

  // Operands follow the walker; the product is registered and lands in the next
  // cycle, together with the RAM read data of the same entry.
  assign op_a = x[walk_pos.row];
  assign op_b = walk_pos.is_rhs ? row_q.source_value : x[walk_pos.col];

  nea_walk #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_walk (
    .clk_i,
    .rst_ni,
    .ctrl_i (walk_ctrl),
    .cols_i (cols_n),
    .pos_o  (walk_pos),
    .addr_o (walk_addr)
  );

  nea_mac u_mac (
    .clk_i,
    .a_i   (op_a),
    .b_i   (op_b),
    .old_i (mac_a_old),
    .sum_o (mac_sum)
  );

  // Entries never written since the last clear read as zero.
  assign mac_a_old = vld_q[wr_addr_q] ? rd_data : '0;

  nea_ram #(
    .WIDTH(SumW),
    .DEPTH(Depth)
  ) u_ram (
    .clk_i,
    .we_i    (wr_pend_q),
    .waddr_i (wr_addr_q),
    .wdata_i (mac_sum),
    .re_i    (rd_en),
    .raddr_i (walk_addr),
    .rdata_o (rd_data)
  );

  always_comb begin
    state_d           = state_q;
    walk_ctrl.start   = 1'b0;
    walk_ctrl.advance = 1'b0;
    rd_en             = 1'b0;
    wr_pend_d         = 1'b0;
    wr_addr_d         = wr_addr_q;
    vld_d             = vld_q;
    out_valid_d       = out_valid_q && !out_ready_i;
    out_d             = out_q;

    if (wr_pend_q) begin
      vld_d[wr_addr_q] = 1'b1;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          walk_ctrl.start = 1'b1;
          state_d         = ST_ACC;
        end
      end
      ST_ACC: begin
        rd_en             = 1'b1;
        wr_pend_d         = 1'b1;
        wr_addr_d         = walk_addr;
        walk_ctrl.advance = 1'b1;
        if (walk_pos.last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last write-back completes here
        if (row_q.last_row) begin
          walk_ctrl.start = 1'b1;
          state_d         = ST_EMIT_RD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT_RD: begin
        if (out_free) begin
          rd_en   = 1'b1;
          state_d = ST_EMIT_WR;
        end
      end
      ST_EMIT_WR: begin
        out_valid_d           = 1'b1;
        out_d.row_index       = walk_pos.row;
        out_d.col_index       = walk_pos.col;
        out_d.is_rhs          = walk_pos.is_rhs;
        out_d.sum_value       = vld_q[walk_addr] ? rd_data : '0;
        out_d.final_entry     = walk_pos.last;
        if (walk_pos.last) begin
          vld_d   = '0;
          state_d = ST_IDLE;
        end else begin
          walk_ctrl.advance = 1'b1;
          state_d           = ST_EMIT_RD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cols_q      <= ColsW'(MAX_COLUMNS);
      wr_pend_q   <= 1'b0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cols_q      <= cols_d;
      wr_pend_q   <= wr_pend_d;
      vld_q       <= vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      row_q <= in_data_i;
    end
    wr_addr_q <= wr_addr_d;
    out_q     <= out_d;
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_final_is_rhs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.final_entry |-> out_data_o.is_rhs)
    else $error("final entry is not an rhs entry");

  a_upper_tri: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.is_rhs |-> out_data_o.col_index >= out_data_o.row_index)
    else $error("Gram entry below the diagonal");

  a_wb_after_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_pend_q |-> $past(state_q == ST_ACC))
    else $error("write-back without an accumulate read");

  a_clear_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT_WR && walk_pos.last |=> vld_q == '0)
    else $error("accumulators not cleared after emission");

  a_no_rd_during_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_pend_q |-> state_q != ST_EMIT_RD && state_q != ST_EMIT_WR)
    else $error("emission overlaps a pending write-back");

endmodule

`default_nettype wire

// ----- tb/normal_equations_accumulator_core_test.sv -----
// ----------------------------------------------------------------------------
// normal_equations_accumulator_core_test
// Self-checking bench for the normal equations accumulator. A short table of
// directed rows, some with hand-computed sums, comes first. Random runs over
// many column counts follow, one of them with no idle cycles on either side.
// Every emitted entry is compared with a software copy of the accumulators.
// Both channels stall at random.
// ----------------------------------------------------------------------------

module normal_equations_accumulator_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import nea_pkg::*;

  localparam int unsigned GramSlots = NeaMaxColumns * (NeaMaxColumns + 1) / 2;
  localparam logic signed [ElemW-1:0] ElemMax = 24'sh7fffff;
  localparam logic signed [ElemW-1:0] ElemMin = 24'sh800000;
  localparam longint SumMax = 64'sh7fff_ffff_ffff_ffff;
  localparam longint SumMin = 64'sh8000_0000_0000_0000;
  // Hand-computed products of the element extremes.
  localparam longint MinTimesMin = 64'sd70368744177664;
  localparam longint MaxTimesMax = 64'sd70368727400449;
  localparam longint MinTimesMax = -64'sd70368735789056;
  localparam int unsigned RandomRows = 265;
  localparam int unsigned IdleWait   = 64;   // outlasts a full 8-column row
  localparam int unsigned DrainWait  = 100;
  localparam int unsigned ReportMax  = 10;

  typedef struct {
    logic [ColsW-1:0] cols;
    nea_in_t          row;
    bit               typed;
    longint           gram_want;
    longint           rhs_want;
  } probe_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [ColsW-1:0] cfg_data_i;
  logic             in_valid_i;
  logic             in_ready_o;
  nea_in_t          in_data_i;
  logic             out_valid_o;
  logic             out_ready_i;
  nea_out_t         out_data_o;

  // Software copy of the accumulators and the column count register.
  longint           gram_acc [GramSlots];
  longint           rhs_acc [NeaMaxColumns];
  logic [ColsW-1:0] cols_now = ColsW'(NeaMaxColumns);
  nea_out_t         entries_due [$];
  int unsigned      mismatch_count = 0;
  bit               no_gaps = 1'b0;
  probe_t           probes [$];

  normal_equations_accumulator_core #(
    .MAX_COLUMNS(NeaMaxColumns)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint widen(logic signed [ElemW-1:0] v);
    return v;
  endfunction

  // 64-bit add clipped to the signed limits.
  function automatic longint sat_sum(longint a, longint b);
    logic signed [SumW:0] s;
    s = a + b;
    if (s[SumW] != s[SumW-1]) return s[SumW] ? SumMin : SumMax;
    return s[SumW-1:0];
  endfunction

  // 0 behaves as one column, anything above the maximum as the maximum.
  function automatic int unsigned cols_in_use();
    if (cols_now == 0) return 1;
    if (cols_now > NeaMaxColumns) return NeaMaxColumns;
    return cols_now;
  endfunction

  // Fold one row into the sums; a last row queues the emitted entries and clears.
  function automatic void accumulate_row(nea_in_t row);
    longint      x [NeaMaxColumns];
    longint      src;
    int unsigned n, slot, r, c;
    nea_out_t    e;
    n = cols_in_use();
    x[0] = widen(row.elem_0);
    x[1] = widen(row.elem_1);
    x[2] = widen(row.elem_2);
    x[3] = widen(row.elem_3);
    x[4] = widen(row.elem_4);
    x[5] = widen(row.elem_5);
    x[6] = widen(row.elem_6);
    x[7] = widen(row.elem_7);
    src  = widen(row.source_value);
    slot = 0;
    for (r = 0; r < NeaMaxColumns; r++) begin
      for (c = r; c < NeaMaxColumns; c++) begin
        if (c < n) gram_acc[slot] = sat_sum(gram_acc[slot], x[r] * x[c]);
        slot++;
      end
      if (r < n) rhs_acc[r] = sat_sum(rhs_acc[r], x[r] * src);
    end
    if (!row.last_row) return;
    slot = 0;
    for (r = 0; r < NeaMaxColumns; r++) begin
      for (c = r; c < NeaMaxColumns; c++) begin
        if (r < n && c < n) begin
          e.row_index   = IdxW'(r);
          e.col_index   = IdxW'(c);
          e.is_rhs      = 1'b0;
          e.sum_value   = gram_acc[slot];
          e.final_entry = 1'b0;
          entries_due.push_back(e);
        end
        slot++;
      end
    end
    for (r = 0; r < n; r++) begin
      e.row_index   = IdxW'(r);
      e.col_index   = '0;
      e.is_rhs      = 1'b1;
      e.sum_value   = rhs_acc[r];
      e.final_entry = (r + 1 == n);
      entries_due.push_back(e);
    end
    foreach (gram_acc[i]) gram_acc[i] = 0;
    foreach (rhs_acc[i]) rhs_acc[i] = 0;
  endfunction

  function automatic nea_in_t flat_row(logic signed [ElemW-1:0] v,
                                       logic signed [ElemW-1:0] src, bit last);
    nea_in_t row;
    row = '{v, v, v, v, v, v, v, v, src, last};
    return row;
  endfunction

  function automatic nea_in_t ramp_row(logic signed [ElemW-1:0] base,
                                       logic signed [ElemW-1:0] step,
                                       logic signed [ElemW-1:0] src, bit last);
    nea_in_t row;
    row = '{base, base + step, base + 2 * step, base + 3 * step, base + 4 * step,
            base + 5 * step, base + 6 * step, base + 7 * step, src, last};
    return row;
  endfunction

  function automatic logic signed [ElemW-1:0] rand_elem();
    case ($urandom_range(9))
      0: return ElemMin;
      1: return ElemMax;
      2: return '0;
      3: return ElemW'($urandom_range(511) - 256);
      default: return ElemW'($urandom);
    endcase
  endfunction

  function automatic nea_in_t random_row(bit last);
    nea_in_t row;
    row = '{rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_elem(),
            rand_elem(), rand_elem(), rand_elem(), rand_elem(), last};
    return row;
  endfunction

  function automatic probe_t probe(logic [ColsW-1:0] cols, nea_in_t row, bit typed = 0,
                                   longint gram_want = 0, longint rhs_want = 0);
    probe_t p;
    p = '{cols, row, typed, gram_want, rhs_want};
    return p;
  endfunction

  function automatic void note_mismatch(nea_out_t want, nea_out_t got);
    mismatch_count++;
    if (mismatch_count <= ReportMax) begin
      $display("%0t: entry mismatch: want r%0d c%0d rhs %0d sum %0d fin %0d",
               $realtime, want.row_index, want.col_index, want.is_rhs, want.sum_value,
               want.final_entry);
      $display("%0t:                 got  r%0d c%0d rhs %0d sum %0d fin %0d",
               $realtime, got.row_index, got.col_index, got.is_rhs, got.sum_value,
               got.final_entry);
    end
  endfunction

  // One row transfer, with random idle cycles ahead of it unless a no-gap
  // stretch is on. A typed row replaces the computed sums by hand-computed ones:
  // one value for every Gram entry and one for every rhs entry.
  task automatic send_row(nea_in_t row, bit typed = 0, longint gram_want = 0,
                          longint rhs_want = 0);
    int unsigned first;
    while (!no_gaps && $urandom_range(99) < 18) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= row;
    do @(posedge clk_i); while (!in_ready_o);
    first = entries_due.size();
    accumulate_row(row);
    if (typed)
      for (int unsigned k = first; k < entries_due.size(); k++)
        entries_due[k].sum_value = entries_due[k].is_rhs ? rhs_want : gram_want;
  endtask

  // Column count write, only once the block has drained and gone quiet.
  task automatic write_cols(logic [ColsW-1:0] v);
    in_valid_i <= 1'b0;
    while (entries_due.size() != 0) @(posedge clk_i);
    repeat (IdleWait) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cols_now = v;
  endtask

  // Receiver side: random back-pressure unless a no-gap stretch is on.
  always @(posedge clk_i) begin
    out_ready_i <= no_gaps || ($urandom_range(99) >= 18);
  end

  // Result checker: every accepted entry against the oldest one due.
  always @(posedge clk_i) begin : check_entries
    nea_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (entries_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= ReportMax)
          $display("%0t: unexpected entry r%0d c%0d rhs %0d sum %0d", $realtime,
                   out_data_o.row_index, out_data_o.col_index, out_data_o.is_rhs,
                   out_data_o.sum_value);
      end else begin
        want = entries_due.pop_front();
        if (out_data_o.row_index !== want.row_index || out_data_o.col_index !== want.col_index
            || out_data_o.is_rhs !== want.is_rhs || out_data_o.sum_value !== want.sum_value
            || out_data_o.final_entry !== want.final_entry)
          note_mismatch(want, out_data_o);
      end
    end
  end

  initial begin
    #40ms;
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    nea_in_t          row;
    logic [ColsW-1:0] v;
    int unsigned      rows_sent, phase, rows_in_phase;
    bit               last;
    rst_ni      <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    foreach (gram_acc[i]) gram_acc[i] = 0;
    foreach (rhs_acc[i]) rhs_acc[i] = 0;

    // Directed rows. The first runs on the reset column count (all 8 in use).
    probes.push_back(probe(8, flat_row(0, 0, 1), 1, 0, 0));
    probes.push_back(probe(8, flat_row(ElemMin, ElemMax, 1), 1, MinTimesMin, MinTimesMax));
    probes.push_back(probe(8, flat_row(ElemMax, ElemMax, 1), 1, MaxTimesMax, MaxTimesMax));
    probes.push_back(probe(8, flat_row(1, -1, 1), 1, 1, -1));
    // Single column: junk in the unused columns must not show up.
    row = flat_row(24'sh5a5a5a, ElemMin, 1);
    row.elem_0 = ElemMin;
    probes.push_back(probe(1, row, 1, MinTimesMin, MinTimesMin));
    // Zero count acts as one column.
    row = flat_row(-7, 5, 1);
    row.elem_0 = 3;
    probes.push_back(probe(0, row, 1, 9, 15));
    // Count above the maximum acts as the maximum.
    probes.push_back(probe(15, flat_row(2, 3, 1), 1, 4, 6));
    // Three-row run on four columns.
    probes.push_back(probe(4, ramp_row(-1000, 300, 77, 0)));
    probes.push_back(probe(4, ramp_row(ElemMax, -24'sd99999, ElemMin, 0)));
    probes.push_back(probe(4, ramp_row(12345, 4321, -24'sd1, 1)));
    // Count raised mid-run: the new columns only hold the later row.
    probes.push_back(probe(3, ramp_row(-24'sd40000, 9000, 600, 0)));
    probes.push_back(probe(5, ramp_row(70000, -24'sd20000, -24'sd3000, 1)));
    // Count lowered mid-run; stale upper columns must be gone after the clear.
    probes.push_back(probe(5, ramp_row(ElemMin, 24'sd1000000, ElemMax, 0)));
    probes.push_back(probe(2, ramp_row(500, 500, 500, 1)));
    probes.push_back(probe(8, flat_row(1, 1, 1), 1, 1, 1));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (probes[i]) begin
      if (probes[i].cols != cols_now) write_cols(probes[i].cols);
      send_row(probes[i].row, probes[i].typed, probes[i].gram_want, probes[i].rhs_want);
    end

    // Random phases, each on a fresh column count. A phase may stop mid-run, so
    // the next count takes over halfway through a run. Phase 2 runs with no gaps.
    rows_sent = 0;
    phase     = 0;
    while (rows_sent < RandomRows) begin
      case ($urandom_range(5))
        0: v = '0;
        1: v = 1;
        2: v = ColsW'(NeaMaxColumns);
        3: v = '1;
        default: v = ColsW'($urandom_range(2, NeaMaxColumns - 1));
      endcase
      write_cols(v);
      no_gaps       = (phase == 2);
      rows_in_phase = $urandom_range(8, 30);
      for (int unsigned k = 0; k < rows_in_phase; k++) begin
        last = ($urandom_range(4) == 0)
               || (k + 1 == rows_in_phase && $urandom_range(3) != 0);
        send_row(random_row(last));
        rows_sent++;
      end
      phase++;
    end
    no_gaps = 1'b0;

    in_valid_i <= 1'b0;
    while (entries_due.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (mismatch_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
